### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same check, written as antecedent and consequent for the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/scpwm_pkg.sv
// Package for the six-channel servo PWM block: widths, reset values, codes.
// No dependencies.
`timescale 1ns / 1ps

package scpwm_pkg;

    // Field and register widths
    localparam int MIN_W    = 10;
    localparam int MAX_W    = 10;
    localparam int PERIOD_W = 12;
    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 12;
    localparam int FI_W     = 8;
    localparam int PIN_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // span * byte fits in 18 bits, 100 * (count - min) in 19 bits
    localparam int PROD_W   = MIN_W + BYTE_W;
    localparam int SCALED_W = TICK_W + 7;

    // Command scale: a byte of 100 means full span
    localparam int CMD_SCALE = 100;

    // Default parameter values
    localparam int FRAME_LIMIT_DEF = 200;
    localparam int CHANNELS_DEF    = 6;

    // Register reset values
    localparam logic [MIN_W-1:0]    PULSE_MIN_RST = 10'd60;
    localparam logic [MAX_W-1:0]    PULSE_MAX_RST = 10'd236;
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 12'd2000;
    localparam logic [BYTE_W-1:0]   DELIM_RST     = 8'h65;
    localparam logic [MIN_W-1:0]    WIDTH_RST     = 10'd100;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MIN = 2'd0,
        REG_PULSE_MAX = 2'd1,
        REG_PERIOD    = 2'd2,
        REG_DELIMITER = 2'd3
    } cfg_reg_t;

    // Input word kinds
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_BYTE = 1'b1
    } cmd_t;

endpackage

### rtl/core/six_channel_servo_pwm_from_frames.sv
// Top level of the six-channel servo PWM generator fed by framed serial bytes.
// Depends on scpwm_pkg.
`timescale 1ns / 1ps

// A result word is registered into the output register, or into the skid word while
// the output stalls. Throughput: one word per cycle while the input is not stalled;
// all state updates in one registered pass. The output register plus one skid word
// hold two result words; the input stalls only while the skid word waits.
// Reset (rst_n low, async): counter and frame index 0, pins low, every channel
// width 100, registers 60 / 236 / 2000 / 0x65, output buffer empty.
module six_channel_servo_pwm_from_frames
    import scpwm_pkg::*;
#(
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF,
    parameter int CHANNELS    = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [BYTE_W-1:0]     rx_byte,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIN_W-1:0]      pin_levels,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [MIN_W-1:0]    pulse_min_reg;
    logic [MAX_W-1:0]    pulse_max_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [BYTE_W-1:0]   delim_reg;

    // Core state; each channel keeps min and span*byte, so width = min + prod/100
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [FI_W-1:0]     frame_index_reg, frame_index_next;
    logic [CHANNELS-1:0] pin_state_reg, pin_state_next;
    logic [MIN_W-1:0]    ch_min_reg  [CHANNELS];
    logic [PROD_W-1:0]   ch_prod_reg [CHANNELS];

    // Output buffer
    logic              out_valid_reg, out_valid_next;
    logic [PIN_W-1:0]  out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [PIN_W-1:0]  skid_data_reg, skid_data_next;

    logic                in_accept, out_pop;
    logic                byte_acc, tick_acc, store_ok;
    logic [MIN_W-1:0]    span;
    logic [PROD_W-1:0]   prod_new;
    logic [TICK_W:0]     tick_inc;
    logic                wrap;
    logic [CHANNELS-1:0] ch_wr, hit;
    logic [TICK_W-1:0]   tick_diff [CHANNELS];
    logic [SCALED_W-1:0] diff_scaled [CHANNELS];
    logic [PIN_W-1:0]    result_word;

    assign cfg_ready  = 1'b1;
    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign pin_levels = out_data_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_pop   = out_valid_reg && !out_stall;
    assign byte_acc  = in_accept && (command == CMD_BYTE);
    assign tick_acc  = in_accept && (command == CMD_TICK);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg <= PULSE_MIN_RST;
            pulse_max_reg <= PULSE_MAX_RST;
            period_reg    <= PERIOD_RST;
            delim_reg     <= DELIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PULSE_MIN: pulse_min_reg <= cfg_data[MIN_W-1:0];
                REG_PULSE_MAX: pulse_max_reg <= cfg_data[MAX_W-1:0];
                REG_PERIOD:    period_reg    <= cfg_data[PERIOD_W-1:0];
                REG_DELIMITER: delim_reg     <= cfg_data[BYTE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Frame handling: byte slot and span product (one 10x8 multiply)
    always_comb
    begin
        span     = (pulse_max_reg >= pulse_min_reg) ? (pulse_max_reg - pulse_min_reg) : '0;
        prod_new = PROD_W'(span) * PROD_W'(rx_byte);
        store_ok = (rx_byte != delim_reg) && (frame_index_reg < FI_W'(FRAME_LIMIT));

        frame_index_next = frame_index_reg;
        if (byte_acc)
            frame_index_next = store_ok ? (frame_index_reg + 1'b1) : '0;

        // slot 0 drives the last channel, slot k drives channel k-1
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (c == CHANNELS - 1)
                ch_wr[c] = byte_acc && store_ok && (frame_index_reg == '0);
            else
                ch_wr[c] = byte_acc && store_ok && (frame_index_reg == FI_W'(c + 1));
        end
    end

    // Tick handling: counter wrap and per-channel compare
    // count > min + floor(prod/100)  <=>  count > min && prod < 100*(count - min)
    always_comb
    begin
        tick_inc = {1'b0, tick_count_reg} + 1'b1;
        wrap     = tick_inc >= {1'b0, period_reg};

        tick_count_next = tick_count_reg;
        if (tick_acc)
            tick_count_next = wrap ? '0 : tick_inc[TICK_W-1:0];

        for (int c = 0; c < CHANNELS; c++)
        begin
            tick_diff[c]   = tick_count_next - TICK_W'(ch_min_reg[c]);
            diff_scaled[c] = SCALED_W'(tick_diff[c]) * SCALED_W'(CMD_SCALE);
            hit[c] = (tick_count_next > TICK_W'(ch_min_reg[c]))
                  && (SCALED_W'(ch_prod_reg[c]) < diff_scaled[c]);
        end

        pin_state_next = pin_state_reg;
        if (tick_acc)
            pin_state_next = (wrap ? '0 : pin_state_reg) | hit;

        result_word = PIN_W'(pin_state_next);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            frame_index_reg <= '0;
            pin_state_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ch_min_reg[c]  <= WIDTH_RST;
                ch_prod_reg[c] <= '0;
            end
        end
        else
        begin
            tick_count_reg  <= tick_count_next;
            frame_index_reg <= frame_index_next;
            pin_state_reg   <= pin_state_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (ch_wr[c])
                begin
                    ch_min_reg[c]  <= pulse_min_reg;
                    ch_prod_reg[c] <= prod_new;
                end
            end
        end
    end

    // Output buffer: result register with a skid word behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result_word;
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload words, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### rtl/core/scpwm_checker.sv
// Port-level checker for the servo PWM top level, attached by bind.
// Depends on scpwm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scpwm_checker
    import scpwm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIN_W-1:0] pin_levels
);

    // Stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pin_levels), "stalled output word changed")

    // Input only stalls when a word already waits at the output
    `ASSERT_CLK(a_stall_needs_out, clk, rst_n, !in_stall || out_valid, "input stalled with empty output")

    // A word accepted into an empty block shows up the next cycle
    `ASSERT_NEXT(a_latency, clk, rst_n, in_valid && !in_stall && !out_valid, out_valid, "accepted word did not reach output")

    // Pins above the channel count stay low
    `ASSERT_CLK(a_unused_pins, clk, rst_n, !out_valid || ((pin_levels >> CHANNELS) == '0), "unused pin driven high")

endmodule

bind six_channel_servo_pwm_from_frames scpwm_checker #(.CHANNELS(CHANNELS)) u_scpwm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pin_levels (pin_levels)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the six-channel servo PWM block: a directed table, then
// random framed byte and tick traffic, checked word by word against a local model or typed-in pins.
// Depends on scpwm_pkg and six_channel_servo_pwm_from_frames.

module tb;
    import scpwm_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RX_HOLD_CYCLES   = 40;
    localparam int BURST_WORDS      = 24;
    localparam int LONG_FRAME_BYTES = FRAME_LIMIT_DEF + 10;
    localparam int unsigned RUN_LIMIT_NS = 4_000_000;

    // Directed table: a word to send or a register to write
    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              sel;
        cmd_t                  cmd;
        logic [CFG_DATA_W-1:0] value;
        logic                  known;
        logic [PIN_W-1:0]      pins;
    } row_t;

    localparam int N_DIRECTED = 26;
    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b1, 6'h00},  // first tick after reset
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd0,    1'b1, 6'h00},  // position 0 -> ch5
        '{ROW_REG,  REG_PERIOD,    CMD_TICK, 12'd3,    1'b0, 6'h00},
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b1, 6'h00},
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b1, 6'h00},  // wrap to 0
        '{ROW_REG,  REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b0, 6'h00},
        '{ROW_REG,  REG_PULSE_MAX, CMD_TICK, 12'd1023, 1'b0, 6'h00},
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd101,  1'b1, 6'h00},  // delimiter
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd0,    1'b1, 6'h00},  // ch5 width 0
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd0,    1'b1, 6'h00},  // ch0 width 0
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd255,  1'b1, 6'h00},  // over-range command
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b1, 6'h21},
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd128,  1'b1, 6'h21},
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b1, 6'h00},  // wrap clears pins
        '{ROW_REG,  REG_PULSE_MIN, CMD_TICK, 12'd1023, 1'b0, 6'h00},
        '{ROW_REG,  REG_PULSE_MAX, CMD_TICK, 12'd0,    1'b0, 6'h00},  // max below min
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd100,  1'b0, 6'h00},
        '{ROW_REG,  REG_PERIOD,    CMD_TICK, 12'd0,    1'b0, 6'h00},  // zero period
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b1, 6'h00},
        '{ROW_REG,  REG_PERIOD,    CMD_TICK, 12'd4095, 1'b0, 6'h00},
        '{ROW_REG,  REG_DELIMITER, CMD_TICK, 12'd0,    1'b0, 6'h00},
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd0,    1'b1, 6'h00},  // zero as delimiter
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd255,  1'b0, 6'h00},
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd255,  1'b1, 6'h01},  // byte ignored on tick
        '{ROW_WORD, REG_PULSE_MIN, CMD_BYTE, 12'd100,  1'b1, 6'h01},  // pins are sticky
        '{ROW_WORD, REG_PULSE_MIN, CMD_TICK, 12'd0,    1'b0, 6'h00}
    };

    // Random phases: register setting, traffic mix and idling per phase
    typedef struct packed {
        logic [MIN_W-1:0]    pmin;
        logic [MAX_W-1:0]    pmax;
        logic [PERIOD_W-1:0] period;
        logic [BYTE_W-1:0]   delim;
        bit [15:0]           words;
        bit [7:0]            tick_pct;
        bit                  tx_idle;
        bit                  rx_idle;
    } phase_t;

    localparam int N_PHASES = 9;
    localparam phase_t PHASES [N_PHASES] = '{
        '{10'd60,   10'd236,  12'd2000, 8'd101, 16'd150, 8'd65, 1'b1, 1'b1},
        '{10'd0,    10'd100,  12'd64,   8'd101, 16'd140, 8'd60, 1'b1, 1'b1},
        '{10'd0,    10'd1023, 12'd4095, 8'd255, 16'd100, 8'd70, 1'b0, 1'b0},
        '{10'd5,    10'd40,   12'd50,   8'd7,   16'd160, 8'd60, 1'b1, 1'b0},
        '{10'd30,   10'd20,   12'd300,  8'd200, 16'd160, 8'd70, 1'b0, 1'b1},
        '{10'd0,    10'd0,    12'd0,    8'd0,   16'd80,  8'd50, 1'b1, 1'b1},
        '{10'd1023, 10'd1023, 12'd1,    8'd128, 16'd80,  8'd50, 1'b1, 1'b1},
        '{10'd3,    10'd700,  12'd900,  8'd101, 16'd160, 8'd85, 1'b1, 1'b1},
        '{10'd60,   10'd236,  12'd2000, 8'd101, 16'd120, 8'd60, 1'b1, 1'b1}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [PIN_W-1:0]      pin_levels;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Sideband for directed rows whose result is typed in
    logic                  drv_known;
    logic [PIN_W-1:0]      drv_pins;

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    // Local servo model: registers and state
    logic [MIN_W-1:0]    servo_min;
    logic [MAX_W-1:0]    servo_max;
    logic [PERIOD_W-1:0] servo_period;
    logic [BYTE_W-1:0]   servo_delim;
    logic [TICK_W-1:0]   servo_count;
    logic [FI_W-1:0]     servo_index;
    logic [TICK_W-1:0]   servo_width [CHANNELS_DEF];
    logic [PIN_W-1:0]    servo_pins;

    logic [PIN_W-1:0] pins_expected [$];

    int unsigned fail_count   = 0;
    int unsigned ticks_taken  = 0;
    int unsigned bytes_taken  = 0;
    int unsigned reg_writes   = 0;
    int unsigned words_checked = 0;

    six_channel_servo_pwm_from_frames u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pin_levels (pin_levels),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the servo model by one word and return the pin levels it leaves
    function automatic logic [PIN_W-1:0] predict_pins(input cmd_t c,
                                                      input logic [BYTE_W-1:0] b);
        int unsigned span;
        int unsigned next_count;
        int          ch;
        int          i;
        if (c == CMD_BYTE) begin
            if (b != servo_delim && servo_index < FRAME_LIMIT_DEF) begin
                // position 0 drives the last channel, the rest shift down by one
                if (servo_index < CHANNELS_DEF) begin
                    ch = (servo_index == 0) ? CHANNELS_DEF - 1 : servo_index - 1;
                    span = (servo_max >= servo_min) ? servo_max - servo_min : 0;
                    servo_width[ch] = TICK_W'(servo_min + (span * b) / CMD_SCALE);
                end
                servo_index = servo_index + 1'b1;
            end else begin
                servo_index = '0;
            end
        end else begin
            next_count = servo_count + 1;
            if (next_count >= servo_period) begin
                next_count = 0;
                servo_pins = '0;
            end
            servo_count = TICK_W'(next_count);
            for (i = 0; i < CHANNELS_DEF; i++)
                if (servo_count > servo_width[i])
                    servo_pins[i] = 1'b1;
        end
        return servo_pins;
    endfunction

    // Port monitor: results first, then register writes, then accepted words
    always @(posedge clk) begin : port_monitor
        logic [PIN_W-1:0] want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                words_checked++;
                if (pins_expected.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %b",
                             $time, pin_levels);
                    fail_count++;
                end else begin
                    want = pins_expected.pop_front();
                    if (pin_levels !== want) begin
                        $display("%0t: pin_levels mismatch, expected %b, got %b",
                                 $time, want, pin_levels);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_reg_t'(cfg_index))
                    REG_PULSE_MIN: servo_min    = cfg_data[MIN_W-1:0];
                    REG_PULSE_MAX: servo_max    = cfg_data[MAX_W-1:0];
                    REG_PERIOD:    servo_period = cfg_data[PERIOD_W-1:0];
                    REG_DELIMITER: servo_delim  = cfg_data[BYTE_W-1:0];
                endcase
            end
            if (in_valid && !in_stall) begin
                want = predict_pins(cmd_t'(command), rx_byte);
                if (drv_known)
                    want = drv_pins;
                pins_expected.push_back(want);
                if (cmd_t'(command) == CMD_TICK)
                    ticks_taken++;
                else
                    bytes_taken++;
            end
        end
    end

    // Result sink: random stall after each word, plus one long hold on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                out_stall = 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            out_stall = (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
            @(posedge clk);
            if (out_valid && !out_stall)
                stall_left = rx_idle_on ? $urandom_range(0, 3) : 0;
        end
    end

    // Offer one word after a random gap; returns at the falling edge after acceptance
    task automatic send_word(input cmd_t c, input logic [BYTE_W-1:0] b,
                             input logic known, input logic [PIN_W-1:0] pins);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        command   = c;
        rx_byte   = b;
        drv_known = known;
        drv_pins  = pins;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Stop sending and wait until every result word is back
    task automatic quiesce();
        in_valid = 1'b0;
        while (pins_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed frames (delimiter then one byte per channel) among ticks
    task automatic run_traffic(input int unsigned n_words, input int unsigned tick_pct);
        int unsigned       k;
        int unsigned       roll;
        int unsigned       frame_pos;
        logic [BYTE_W-1:0] b;
        frame_pos = 0;
        for (k = 0; k < n_words; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct) begin
                send_word(CMD_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            end else if (roll < 96) begin
                if (frame_pos == 0)
                    b = servo_delim;
                else if ($urandom_range(0, 4) == 0)
                    b = BYTE_W'($urandom_range(0, 255));
                else
                    b = BYTE_W'($urandom_range(0, CMD_SCALE));
                frame_pos = (frame_pos == CHANNELS_DEF) ? 0 : frame_pos + 1;
                send_word(CMD_BYTE, b, 1'b0, '0);
            end else begin
                // stray byte that may break the frame
                send_word(CMD_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
    endtask

    initial begin : stimulus
        int i;
        int r;
        int p;
        in_valid  = 1'b0;
        command   = CMD_TICK;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PULSE_MIN;
        cfg_data  = '0;
        drv_known = 1'b0;
        drv_pins  = '0;
        servo_min    = PULSE_MIN_RST;
        servo_max    = PULSE_MAX_RST;
        servo_period = PERIOD_RST;
        servo_delim  = DELIM_RST;
        servo_count  = '0;
        servo_index  = '0;
        servo_pins   = '0;
        for (i = 0; i < CHANNELS_DEF; i++)
            servo_width[i] = TICK_W'(WIDTH_RST);
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_REG) begin
                quiesce();
                write_reg(DIRECTED[r].sel, DIRECTED[r].value);
            end else begin
                send_word(DIRECTED[r].cmd, DIRECTED[r].value[BYTE_W-1:0],
                          DIRECTED[r].known, DIRECTED[r].pins);
            end
        end

        // random phases, one register setting each
        for (p = 0; p < N_PHASES; p++) begin
            quiesce();
            write_reg(REG_PULSE_MIN, CFG_DATA_W'(PHASES[p].pmin));
            write_reg(REG_PULSE_MAX, CFG_DATA_W'(PHASES[p].pmax));
            write_reg(REG_PERIOD, PHASES[p].period);
            write_reg(REG_DELIMITER, CFG_DATA_W'(PHASES[p].delim));
            tx_idle_on = PHASES[p].tx_idle;
            rx_idle_on = PHASES[p].rx_idle;
            if (p == 1) begin
                // sink holds off while words keep coming, so the block backs up
                rx_hold_req = 1'b1;
                tx_idle_on  = 1'b0;
                for (i = 0; i < BURST_WORDS; i++)
                    send_word(cmd_t'($urandom_range(0, 1)),
                              BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                quiesce();
                tx_idle_on = PHASES[p].tx_idle;
            end
            if (p == 2) begin
                // over-long frame: the index hits its limit and starts over
                send_word(CMD_BYTE, servo_delim, 1'b0, '0);
                for (i = 0; i < LONG_FRAME_BYTES; i++)
                    send_word(CMD_BYTE, BYTE_W'($urandom_range(0, 254)), 1'b0, '0);
            end
            run_traffic(PHASES[p].words, PHASES[p].tick_pct);
        end

        quiesce();
        $display("covered %0d ticks and %0d bytes across %0d register writes",
                 ticks_taken, bytes_taken, reg_writes);
        $display("checked %0d result words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("timeout with %0d result words outstanding", pins_expected.size());
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/scpwm_pkg.sv
rtl/core/six_channel_servo_pwm_from_frames.sv
rtl/core/scpwm_checker.sv
tb/sv/tb.sv
